// ----- design/ssl_pkg.sv -----
// shared types and constants of the sorted sequential list
package ssl_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int REQ_W    = 2;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;

  // search tree: groups of eight cells, then a merge over the groups
  localparam int GRP_SIZE = 8;
  localparam int GRP_W    = $clog2(GRP_SIZE);
  localparam int NGRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int NGRP_W   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD      = NGRP * GRP_SIZE;
  localparam int FIDX_W   = NGRP_W + GRP_W;

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    data_t            value;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [POS_W-1:0]   position;
    logic [COUNT_W-1:0] count;
  } out_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LOWER,
    CELL_FROM_UPPER
  } cell_cmd_t;

  typedef struct packed {
    logic              has_le;
    logic [FIDX_W-1:0] last_le;
    logic              has_eq;
    logic [FIDX_W-1:0] first_eq;
  } find_t;

endpackage

// ----- design/ssl_cell.sv -----
// one list cell: holds an entry, compares it with the key, takes a neighbor's entry
module ssl_cell (
  input  logic              clk,
  input  ssl_pkg::cell_cmd_t cmd,
  input  ssl_pkg::data_t    key,
  input  ssl_pkg::data_t    lower,
  input  ssl_pkg::data_t    upper,
  output ssl_pkg::data_t    entry,
  output logic              gt,
  output logic              eq
);
  import ssl_pkg::*;

  always_ff @(posedge clk) begin
    case (cmd)
      CELL_HOLD:       entry <= entry;
      CELL_LOAD:       entry <= key;
      CELL_FROM_LOWER: entry <= lower;
      CELL_FROM_UPPER: entry <= upper;
      default:         entry <= entry;
    endcase
  end

  assign gt = entry > key;
  assign eq = entry == key;

endmodule

// ----- design/ssl_find.sv -----
// registered two-level search: last cell not above the key, first cell equal to it
module ssl_find (
  input  logic                           clk,
  input  logic [ssl_pkg::CAPACITY-1:0]   le,
  input  logic [ssl_pkg::CAPACITY-1:0]   eq,
  output ssl_pkg::find_t                 res
);
  import ssl_pkg::*;

  logic [PAD-1:0]   le_q;
  logic [PAD-1:0]   eq_q;
  logic [NGRP-1:0]  grp_le;
  logic [NGRP-1:0]  grp_eq;
  logic [GRP_W-1:0] grp_le_idx [NGRP];
  logic [GRP_W-1:0] grp_eq_idx [NGRP];

  logic [NGRP-1:0]  grp_le_next;
  logic [NGRP-1:0]  grp_eq_next;
  logic [GRP_W-1:0] grp_le_idx_next [NGRP];
  logic [GRP_W-1:0] grp_eq_idx_next [NGRP];
  find_t            res_next;

  // stage 0: flags from the cells
  always_ff @(posedge clk) begin
    le_q <= PAD'(le);
    eq_q <= PAD'(eq);
  end

  // stage 1: inside each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_le_next[g]     = 1'b0;
      grp_eq_next[g]     = 1'b0;
      grp_le_idx_next[g] = '0;
      grp_eq_idx_next[g] = '0;
      for (int j = 0; j < GRP_SIZE; j++) begin
        if (le_q[g*GRP_SIZE + j]) begin
          grp_le_next[g]     = 1'b1;
          grp_le_idx_next[g] = GRP_W'(j);
        end
      end
      for (int j = GRP_SIZE - 1; j >= 0; j--) begin
        if (eq_q[g*GRP_SIZE + j]) begin
          grp_eq_next[g]     = 1'b1;
          grp_eq_idx_next[g] = GRP_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_le     <= grp_le_next;
    grp_eq     <= grp_eq_next;
    grp_le_idx <= grp_le_idx_next;
    grp_eq_idx <= grp_eq_idx_next;
  end

  // stage 2: across the groups
  always_comb begin
    res_next = '0;
    for (int g = 0; g < NGRP; g++) begin
      if (grp_le[g]) begin
        res_next.has_le  = 1'b1;
        res_next.last_le = {NGRP_W'(g), grp_le_idx[g]};
      end
    end
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_eq[g]) begin
        res_next.has_eq   = 1'b1;
        res_next.first_eq = {NGRP_W'(g), grp_eq_idx[g]};
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

// ----- design/sorted_sequential_list.sv -----
// Sorted sequential list of signed 32-bit entries held in a row of cells. A request
// (append, sorted insert, delete first match) is taken when in_valid and in_ready are
// high and answers with one result: status, position touched and new count. The block
// works on one request at a time: it captures the request, runs the registered search
// over the cell compare flags (flag capture, per-group encode, merge across groups) and
// then, in the apply step, the affected cells shift or load at once and the result is
// registered. A result waiting on out_ready does not stop the next request from being
// taken; only its apply step waits.
module sorted_sequential_list (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ssl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ssl_pkg::out_t out_data
);
  import ssl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLAGS,
    S_GROUP,
    S_MERGE,
    S_APPLY
  } state_t;

  state_t            state;
  logic [REQ_W-1:0]  req;
  data_t             key;
  logic [CNT_W-1:0]  count;

  data_t             entries [CAPACITY];
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY-1:0] le_v;
  logic [CAPACITY-1:0] eq_v;
  cell_cmd_t         cmd [CAPACITY];
  find_t             found;

  logic              go;
  logic [STAT_W-1:0] status_next;
  logic [CNT_W-1:0]  pos_next;
  logic [CNT_W-1:0]  count_next;
  logic              do_app;
  logic              do_ins;
  logic              do_del;
  logic [CNT_W-1:0]  gap;
  logic [CNT_W-1:0]  del_pos;

  assign in_ready = state == S_IDLE;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t lower;
    data_t upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_low
      assign lower = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = '0;
    end else begin : g_up
      assign upper = entries[i+1];
    end
    ssl_cell u_cell (
      .clk   (clk),
      .cmd   (cmd[i]),
      .key   (key),
      .lower (lower),
      .upper (upper),
      .entry (entries[i]),
      .gt    (gt[i]),
      .eq    (eq[i])
    );
  end

  // only cells below the count take part in the search
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      le_v[i] = (CNT_W'(i) < count) && !gt[i];
      eq_v[i] = (CNT_W'(i) < count) && eq[i];
    end
  end

  ssl_find u_find (
    .clk (clk),
    .le  (le_v),
    .eq  (eq_v),
    .res (found)
  );

  assign go      = (state == S_APPLY) && (!out_valid || out_ready);
  assign gap     = found.has_le ? CNT_W'(found.last_le) + CNT_W'(1) : '0;
  assign del_pos = CNT_W'(found.first_eq);

  always_comb begin
    status_next = ST_OK;
    pos_next    = '0;
    count_next  = count;
    do_app      = 1'b0;
    do_ins      = 1'b0;
    do_del      = 1'b0;
    case (req)
      REQ_APPEND: begin
        if (count == CNT_W'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          do_app     = 1'b1;
          pos_next   = count;
          count_next = count + CNT_W'(1);
        end
      end
      REQ_INSERT: begin
        if (count == CNT_W'(CAPACITY)) begin
          status_next = ST_FULL;
        end else begin
          do_ins     = 1'b1;
          pos_next   = gap;
          count_next = count + CNT_W'(1);
        end
      end
      REQ_DELETE: begin
        if (count == '0) begin
          status_next = ST_EMPTY;
        end else if (!found.has_eq) begin
          status_next = ST_NOT_FOUND;
        end else begin
          do_del     = 1'b1;
          pos_next   = del_pos;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cmd[i] = CELL_HOLD;
      if (go) begin
        if (do_app && CNT_W'(i) == count) begin
          cmd[i] = CELL_LOAD;
        end else if (do_ins && CNT_W'(i) == gap) begin
          cmd[i] = CELL_LOAD;
        end else if (do_ins && CNT_W'(i) > gap && CNT_W'(i) <= count) begin
          cmd[i] = CELL_FROM_LOWER;
        end else if (do_del && CNT_W'(i) >= del_pos && CNT_W'(i) + CNT_W'(1) < count) begin
          cmd[i] = CELL_FROM_UPPER;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data.req_type;
            key   <= in_data.value;
            state <= S_FLAGS;
          end
        end
        S_FLAGS: state <= S_GROUP;
        S_GROUP: state <= S_MERGE;
        S_MERGE: state <= S_APPLY;
        S_APPLY: begin
          if (go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (go) begin
        count             <= count_next;
        out_valid         <= 1'b1;
        out_data.status   <= status_next;
        out_data.position <= POS_W'(pos_next);
        out_data.count    <= COUNT_W'(count_next);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/ssl_check.sv -----
// port checks of the sorted sequential list and their binding
module ssl_check (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input ssl_pkg::out_t out_data
);
  import ssl_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FULL |-> out_data.count == COUNT_W'(CAPACITY))
    else $error("full status with room left");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_EMPTY |-> out_data.count == '0)
    else $error("empty status with entries");

  a_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |-> out_data.position == '0)
    else $error("position set on failed request");

endmodule

bind sorted_sequential_list ssl_check u_ssl_check (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/testbench.sv -----
// self-checking testbench for the sorted sequential list with a built-in list predictor
module testbench;
  import ssl_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES = 20;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  out_t  out_data;

  sorted_sequential_list u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  in_t   request_q [$];
  out_t  answer_q [$];
  data_t gen_live [$];

  data_t       list_mem [CAPACITY];
  int unsigned list_len = 0;
  int unsigned peak_len = 0;
  int          stat_hits [4];

  int   tx_idle = 0;
  int   rx_idle = 0;
  int   items_issued = 0;
  int   items_taken = 0;
  int   errors = 0;
  int   idle_cycles = 0;
  logic in_taken = 1'b0;
  logic growing = 1'b1;
  out_t want;

  // list behavior: append, ordered insert after equal entries, delete first match
  function automatic out_t apply_request(in_t req);
    out_t        res;
    int unsigned slot;
    res = '0;
    case (req.req_type)
      REQ_APPEND, REQ_INSERT: begin
        if (list_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          slot = list_len;
          if (req.req_type == REQ_INSERT) begin
            while (slot > 0 && $signed(list_mem[slot-1]) > $signed(req.value)) begin
              list_mem[slot] = list_mem[slot-1];
              slot--;
            end
          end
          list_mem[slot] = req.value;
          list_len++;
          res.status = ST_OK;
          res.position = slot[POS_W-1:0];
        end
      end
      REQ_DELETE: begin
        if (list_len == 0) begin
          res.status = ST_EMPTY;
        end else begin
          slot = 0;
          while (slot < list_len && list_mem[slot] != req.value) slot++;
          if (slot == list_len) begin
            res.status = ST_NOT_FOUND;
          end else begin
            res.status = ST_OK;
            res.position = slot[POS_W-1:0];
            while (slot + 1 < list_len) begin
              list_mem[slot] = list_mem[slot+1];
              slot++;
            end
            list_len--;
          end
        end
      end
      default: res.status = ST_OK;
    endcase
    res.count = list_len[COUNT_W-1:0];
    stat_hits[res.status]++;
    if (list_len > peak_len) peak_len = list_len;
    return res;
  endfunction

  // driver: new transfer or idle at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (request_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
          in_data <= request_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // monitor, predictor and watchdog at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        answer_q.push_back(apply_request(in_data));
        items_taken++;
      end
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result status %0d position %0d count %0d", $time,
                   out_data.status, out_data.position, out_data.count);
        end else begin
          want = answer_q.pop_front();
          if (out_data.status !== want.status || out_data.position !== want.position ||
              out_data.count !== want.count) begin
            errors++;
            $display("%0t: expected status %0d position %0d count %0d, got %0d %0d %0d",
                     $time, want.status, want.position, want.count,
                     out_data.status, out_data.position, out_data.count);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // queue one request and keep the generator's view of the list contents
  task automatic queue_request(logic [REQ_W-1:0] kind, data_t v);
    in_t req;
    int  i;
    req.req_type = kind;
    req.value = v;
    request_q.push_back(req);
    items_issued++;
    if (kind == REQ_APPEND || kind == REQ_INSERT) begin
      if (gen_live.size() < CAPACITY) gen_live.push_back(v);
    end else if (kind == REQ_DELETE) begin
      i = 0;
      while (i < gen_live.size() && gen_live[i] != v) i++;
      if (i < gen_live.size()) gen_live.delete(i);
    end
  endtask

  function automatic data_t pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 40) return data_t'(int'($urandom_range(16)) - 8);
    if (r < 50) begin
      case ($urandom_range(5))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h8000_0001;
        3: return 32'h7fff_fffe;
        4: return -1;
        default: return 0;
      endcase
    end
    return data_t'($urandom);
  endfunction

  // random walk of the list length between empty and full
  task automatic queue_random(int n);
    int    k;
    int    r;
    data_t key;
    for (k = 0; k < n; k++) begin
      if (gen_live.size() == CAPACITY && $urandom_range(99) < 30) growing = 1'b0;
      else if (gen_live.size() == 0 && $urandom_range(99) < 50) growing = 1'b1;
      else if ($urandom_range(99) == 0) growing = ~growing;
      r = $urandom_range(99);
      if (r < 3) begin
        queue_request(REQ_UNUSED, data_t'($urandom));
      end else if ((growing && r < 80) || (!growing && r >= 78)) begin
        queue_request(($urandom_range(99) < 60) ? REQ_INSERT : REQ_APPEND, pick_value());
      end else begin
        if (gen_live.size() != 0 && $urandom_range(99) < 75)
          key = gen_live[$urandom_range(gen_live.size() - 1)];
        else
          key = pick_value();
        queue_request(REQ_DELETE, key);
      end
    end
  endtask

  task automatic drain();
    while (items_taken != items_issued || answer_q.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(int tx, int rx, int n);
    @(posedge clk);
    tx_idle = tx;
    rx_idle = rx;
    queue_random(n);
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    queue_request(REQ_DELETE, 0);
    queue_request(REQ_UNUSED, 0);
    queue_request(REQ_INSERT, 0);
    queue_request(REQ_INSERT, 32'h7fff_ffff);
    queue_request(REQ_INSERT, 32'h8000_0000);
    queue_request(REQ_INSERT, 0);
    queue_request(REQ_INSERT, -1);
    queue_request(REQ_INSERT, 5);
    queue_request(REQ_APPEND, -7);
    queue_request(REQ_APPEND, 32'h8000_0000);
    queue_request(REQ_DELETE, 12345);
    queue_request(REQ_DELETE, 0);
    queue_request(REQ_DELETE, 32'h8000_0000);
    queue_request(REQ_DELETE, 32'h7fff_ffff);
    queue_request(REQ_UNUSED, 32'hffff_ffff);
    queue_request(REQ_DELETE, 32'h8000_0000);
    queue_request(REQ_DELETE, -7);
    queue_request(REQ_DELETE, -1);
    queue_request(REQ_DELETE, 5);
    queue_request(REQ_DELETE, 0);
    queue_request(REQ_DELETE, 0);
    drain();
    run_phase(35, 64, 420);
    run_phase(64, 35, 420);
    run_phase(0, 0, 410);
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("%0d requests: %0d ok, %0d full, %0d empty, %0d key absent", items_taken,
             stat_hits[ST_OK], stat_hits[ST_FULL], stat_hits[ST_EMPTY],
             stat_hits[ST_NOT_FOUND]);
    $display("list length peaked at %0d of %0d entries", peak_len, CAPACITY);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/ssl_pkg.sv
design/ssl_cell.sv
design/ssl_find.sv
design/sorted_sequential_list.sv
design/ssl_check.sv
tb/testbench.sv
